// ----- hw/rtl/smd_pkg.sv -----
`default_nettype none
package smd_pkg;

  localparam int STACK_DEPTH = 1024;
  localparam int MEM_CELLS   = 4096;
  localparam int CELL_W      = 64;
  // stack index runs 0..STACK_DEPTH inclusive
  localparam int SI_W        = $clog2(STACK_DEPTH + 1);
  localparam int SP_AW       = $clog2(STACK_DEPTH);
  localparam int MEM_AW      = $clog2(MEM_CELLS);
  localparam int CNT_W       = $clog2(CELL_W);

  typedef enum logic [4:0] {
    OP_LIT     = 5'd0,
    OP_CELL    = 5'd1,
    OP_ADD     = 5'd2,
    OP_SUB     = 5'd3,
    OP_MUL     = 5'd4,
    OP_AND     = 5'd5,
    OP_OR      = 5'd6,
    OP_XOR     = 5'd7,
    OP_LT      = 5'd8,
    OP_ULT     = 5'd9,
    OP_EQ      = 5'd10,
    OP_SHL     = 5'd11,
    OP_SHR     = 5'd12,
    OP_SAR     = 5'd13,
    OP_DIVMOD  = 5'd14,
    OP_FETCH   = 5'd15,
    OP_STORE   = 5'd16,
    OP_CFETCH  = 5'd17,
    OP_CSTORE  = 5'd18,
    OP_DSPGET  = 5'd19,
    OP_DSPSET  = 5'd20,
    OP_EMIT    = 5'd21,
    OP_BRANCH0 = 5'd22
  } op_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_UNDER = 3'd1,
    ST_OVER  = 3'd2,
    ST_DIV0  = 3'd3,
    ST_ADDR  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_ITER,
    S_MEM,
    S_WB,
    S_WB2,
    S_TOP,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [4:0]         op;
    logic signed [63:0] literal;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] top_value;
    logic [10:0]        depth;
    logic               emit_valid;
    logic [7:0]         emit_char;
    logic               branch_taken;
    logic [2:0]         status;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic rd_ops;
    logic exec;
    logic mem;
    logic wb;
    logic wb2;
    logic rd_top;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic ex_iter;
    logic ex_mem;
    logic wr2;
    logic md_done;
  } dp_sts_t;

endpackage
`default_nettype wire

// ----- hw/rtl/smd_muldiv.sv -----
`default_nettype none
// Shared radix-2 multiply / restoring divide, one bit per cycle
module smd_muldiv (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic                       is_div,
  input  wire logic [smd_pkg::CELL_W-1:0] opa,
  input  wire logic [smd_pkg::CELL_W-1:0] opb,
  output logic                            done,
  output logic [smd_pkg::CELL_W-1:0]      prod,
  output logic [smd_pkg::CELL_W-1:0]      quot,
  output logic [smd_pkg::CELL_W-1:0]      rem
);

  logic                         busy_r;
  logic                         done_r;
  logic                         div_r;
  logic [smd_pkg::CNT_W-1:0]    cnt_r;
  logic [smd_pkg::CELL_W:0]     x_r;    // multiplicand or partial remainder
  logic [smd_pkg::CELL_W-1:0]   y_r;    // multiplier or quotient
  logic [smd_pkg::CELL_W-1:0]   d_r;    // divisor
  logic [smd_pkg::CELL_W-1:0]   acc_r;
  logic [smd_pkg::CELL_W:0]     rs;
  logic                         ge;

  assign rs = {x_r[smd_pkg::CELL_W-1:0], y_r[smd_pkg::CELL_W-1]};
  assign ge = (rs >= {1'b0, d_r});

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == smd_pkg::CNT_W'(smd_pkg::CELL_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // iteration
  always_ff @(posedge clk) begin
    if (start) begin
      div_r <= is_div;
      acc_r <= '0;
      d_r   <= opb;
      if (is_div) begin
        x_r <= '0;
        y_r <= opa;
      end else begin
        x_r <= {1'b0, opa};
        y_r <= opb;
      end
    end else if (busy_r) begin
      if (div_r) begin
        x_r <= ge ? (rs - {1'b0, d_r}) : rs;
        y_r <= {y_r[smd_pkg::CELL_W-2:0], ge};
      end else begin
        if (y_r[0]) begin
          acc_r <= acc_r + x_r[smd_pkg::CELL_W-1:0];
        end
        x_r <= {x_r[smd_pkg::CELL_W-1:0], 1'b0};
        y_r <= {1'b0, y_r[smd_pkg::CELL_W-1:1]};
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;
  assign quot = y_r;
  assign rem  = x_r[smd_pkg::CELL_W-1:0];

endmodule
`default_nettype wire

// ----- hw/rtl/smd_dpath.sv -----
`default_nettype none
// Datapath: stack memory, cell memory, stack index, ALU, mul/div unit
module smd_dpath (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire smd_pkg::ctrl_cmd_t  cmd,
  input  wire smd_pkg::in_item_t   in_item,
  output smd_pkg::dp_sts_t         sts,
  output smd_pkg::out_item_t       res
);

  localparam int CW = smd_pkg::CELL_W;
  localparam int SW = smd_pkg::SI_W;
  localparam int PA = smd_pkg::SP_AW;
  localparam int MA = smd_pkg::MEM_AW;

  logic [CW-1:0]    stk_mem [smd_pkg::STACK_DEPTH];
  logic [CW-1:0]    dmem    [smd_pkg::MEM_CELLS];

  logic [4:0]       op_r;
  logic [CW-1:0]    lit_r;
  logic [SW-1:0]    si_r;
  logic [SW-1:0]    nsi_r;
  logic [CW-1:0]    a_r;     // second item
  logic [CW-1:0]    b_r;     // top item
  logic [CW-1:0]    dm_rd_r;
  logic [2:0]       st_r;
  logic             ev_r;
  logic [7:0]       ec_r;
  logic             bt_r;
  logic             pw_en_r;
  logic [PA-1:0]    pw_addr_r;
  logic [CW-1:0]    pw_val_r;
  logic             wr2_r;

  logic [SW-1:0]    d;
  logic [SW-1:0]    si_m1;
  logic [SW-1:0]    si_p1;
  logic [SW-1:0]    si_p2;
  logic             byte_ok;
  logic             cell_ok;
  logic [5:0]       shamt;
  logic [CW-1:0]    alu;
  logic [MA-1:0]    cidx;
  logic [2:0]       boff;
  logic [7:0]       cbyte;
  logic [CW-1:0]    merged;

  logic [2:0]       x_st;
  logic [SW-1:0]    x_nsi;
  logic             x_pwen;
  logic [PA-1:0]    x_pwaddr;
  logic [CW-1:0]    x_pwval;
  logic             x_ev;
  logic             x_bt;
  logic             x_iter;
  logic             x_mem;
  logic             x_wr2;
  logic             x_dmwe;

  logic             md_done;
  logic [CW-1:0]    md_prod;
  logic [CW-1:0]    md_quot;
  logic [CW-1:0]    md_rem;

  logic             stk_we;
  logic [PA-1:0]    stk_wa;
  logic [CW-1:0]    stk_wd;
  logic             dm_we;
  logic [CW-1:0]    dm_wd;
  logic [SW-1:0]    d_now;

  assign d     = SW'(smd_pkg::STACK_DEPTH) - si_r;
  assign si_m1 = si_r - 1'b1;
  assign si_p1 = si_r + 1'b1;
  assign si_p2 = si_r + SW'(2);
  assign shamt = b_r[5:0];
  assign cidx  = b_r[MA+2:3];
  assign boff  = b_r[2:0];
  assign byte_ok = (b_r[CW-1:MA+3] == '0);
  assign cell_ok = byte_ok && (boff == 3'd0);
  assign cbyte   = dm_rd_r[{boff, 3'b000} +: 8];

  // byte lane merge for cstore
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      merged[8*j +: 8] = (boff == 3'(j)) ? a_r[7:0] : dm_rd_r[8*j +: 8];
    end
  end

  // ALU for the binary ops other than mul and divmod ( a b -- a op b )
  always_comb begin
    unique case (op_r)
      smd_pkg::OP_ADD: alu = a_r + b_r;
      smd_pkg::OP_SUB: alu = a_r - b_r;
      smd_pkg::OP_AND: alu = a_r & b_r;
      smd_pkg::OP_OR:  alu = a_r | b_r;
      smd_pkg::OP_XOR: alu = a_r ^ b_r;
      smd_pkg::OP_LT:  alu = CW'($signed(a_r) < $signed(b_r));
      smd_pkg::OP_ULT: alu = CW'(a_r < b_r);
      smd_pkg::OP_EQ:  alu = CW'(a_r == b_r);
      smd_pkg::OP_SHL: alu = a_r << shamt;
      smd_pkg::OP_SHR: alu = a_r >> shamt;
      smd_pkg::OP_SAR: alu = $unsigned($signed(a_r) >>> shamt);
      default:         alu = '0;
    endcase
  end

  // decode, checks and pending stack write
  always_comb begin
    x_st     = smd_pkg::ST_OK;
    x_nsi    = si_r;
    x_pwen   = 1'b0;
    x_pwaddr = si_p1[PA-1:0];
    x_pwval  = alu;
    x_ev     = 1'b0;
    x_bt     = 1'b0;
    x_iter   = 1'b0;
    x_mem    = 1'b0;
    x_wr2    = 1'b0;
    x_dmwe   = 1'b0;
    unique case (op_r)
      smd_pkg::OP_LIT, smd_pkg::OP_CELL, smd_pkg::OP_DSPGET: begin
        if (si_r == '0) begin
          x_st = smd_pkg::ST_OVER;
        end else begin
          x_pwen   = 1'b1;
          x_pwaddr = si_m1[PA-1:0];
          x_nsi    = si_m1;
          if (op_r == smd_pkg::OP_LIT) x_pwval = lit_r;
          else if (op_r == smd_pkg::OP_CELL) x_pwval = CW'(8);
          else x_pwval = CW'(si_r);
        end
      end
      smd_pkg::OP_ADD, smd_pkg::OP_SUB, smd_pkg::OP_AND, smd_pkg::OP_OR,
      smd_pkg::OP_XOR, smd_pkg::OP_LT, smd_pkg::OP_ULT, smd_pkg::OP_EQ,
      smd_pkg::OP_SHL, smd_pkg::OP_SHR, smd_pkg::OP_SAR, smd_pkg::OP_MUL: begin
        if (d < SW'(2)) begin
          x_st = smd_pkg::ST_UNDER;
        end else begin
          x_pwen = 1'b1;
          x_nsi  = si_p1;
          x_iter = (op_r == smd_pkg::OP_MUL);
        end
      end
      smd_pkg::OP_DIVMOD: begin
        if (d < SW'(2)) begin
          x_st = smd_pkg::ST_UNDER;
        end else if (b_r == '0) begin
          x_st = smd_pkg::ST_DIV0;
        end else begin
          x_pwen = 1'b1;
          x_iter = 1'b1;
          x_wr2  = 1'b1;
        end
      end
      smd_pkg::OP_FETCH, smd_pkg::OP_CFETCH: begin
        if (d < SW'(1)) begin
          x_st = smd_pkg::ST_UNDER;
        end else if ((op_r == smd_pkg::OP_FETCH) ? !cell_ok : !byte_ok) begin
          x_st = smd_pkg::ST_ADDR;
        end else begin
          x_pwen   = 1'b1;
          x_pwaddr = si_r[PA-1:0];
          x_mem    = 1'b1;
        end
      end
      smd_pkg::OP_STORE, smd_pkg::OP_CSTORE: begin
        if (d < SW'(2)) begin
          x_st = smd_pkg::ST_UNDER;
        end else if ((op_r == smd_pkg::OP_STORE) ? !cell_ok : !byte_ok) begin
          x_st = smd_pkg::ST_ADDR;
        end else begin
          x_nsi  = si_p2;
          x_dmwe = (op_r == smd_pkg::OP_STORE);
          x_mem  = (op_r == smd_pkg::OP_CSTORE);
        end
      end
      smd_pkg::OP_DSPSET: begin
        if (d < SW'(1)) begin
          x_st = smd_pkg::ST_UNDER;
        end else if (b_r > CW'(smd_pkg::STACK_DEPTH)) begin
          x_st = smd_pkg::ST_ADDR;
        end else begin
          x_nsi = b_r[SW-1:0];
        end
      end
      smd_pkg::OP_EMIT, smd_pkg::OP_BRANCH0: begin
        if (d < SW'(1)) begin
          x_st = smd_pkg::ST_UNDER;
        end else begin
          x_nsi = si_p1;
          x_ev  = (op_r == smd_pkg::OP_EMIT);
          x_bt  = (op_r == smd_pkg::OP_BRANCH0) && (b_r == '0);
        end
      end
      default: begin
      end
    endcase
  end

  // item and step registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      si_r <= SW'(smd_pkg::STACK_DEPTH);
    end else if (cmd.wb) begin
      si_r <= nsi_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_item.op;
      lit_r <= in_item.literal;
    end
    if (cmd.exec) begin
      st_r      <= x_st;
      nsi_r     <= x_nsi;
      pw_en_r   <= x_pwen;
      pw_addr_r <= x_pwaddr;
      pw_val_r  <= x_pwval;
      ev_r      <= x_ev;
      ec_r      <= b_r[7:0];
      bt_r      <= x_bt;
      wr2_r     <= x_wr2;
    end else if (md_done) begin
      pw_val_r <= (op_r == smd_pkg::OP_DIVMOD) ? md_rem : md_prod;
    end else if (cmd.mem) begin
      pw_val_r <= (op_r == smd_pkg::OP_FETCH) ? dm_rd_r : {{(CW-8){cbyte[7]}}, cbyte};
    end
  end

  // stack memory: one write, two registered reads
  assign stk_we = (cmd.wb && pw_en_r) || cmd.wb2;
  assign stk_wa = cmd.wb2 ? si_r[PA-1:0] : pw_addr_r;
  assign stk_wd = cmd.wb2 ? md_quot : pw_val_r;

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    if (cmd.rd_ops || cmd.rd_top) begin
      b_r <= stk_mem[si_r[PA-1:0]];
    end
    if (cmd.rd_ops) begin
      a_r <= stk_mem[si_p1[PA-1:0]];
    end
  end

  // cell memory: store writes at exec, cstore merges after the read
  assign dm_we = (cmd.exec && x_dmwe) ||
                 (cmd.mem && (op_r == smd_pkg::OP_CSTORE));
  assign dm_wd = cmd.exec ? a_r : merged;

  always_ff @(posedge clk) begin
    if (dm_we) begin
      dmem[cidx] <= dm_wd;
    end
    if (cmd.exec) begin
      dm_rd_r <= dmem[cidx];
    end
  end

  smd_muldiv u_muldiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.exec && x_iter),
    .is_div (op_r == smd_pkg::OP_DIVMOD),
    .opa    (a_r),
    .opb    (b_r),
    .done   (md_done),
    .prod   (md_prod),
    .quot   (md_quot),
    .rem    (md_rem)
  );

  assign sts.ex_iter = x_iter;
  assign sts.ex_mem  = x_mem;
  assign sts.wr2     = wr2_r;
  assign sts.md_done = md_done;

  // result item, valid once the new top has been read
  assign d_now            = SW'(smd_pkg::STACK_DEPTH) - si_r;
  assign res.top_value    = (d_now != '0) ? b_r : '0;
  assign res.depth        = 11'(d_now);
  assign res.emit_valid   = ev_r;
  assign res.emit_char    = ev_r ? ec_r : 8'd0;
  assign res.branch_taken = bt_r;
  assign res.status       = st_r;

endmodule
`default_nettype wire

// ----- hw/rtl/smd_ctrl.sv -----
`default_nettype none
// Step sequencer
module smd_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               out_free,
  input  wire smd_pkg::dp_sts_t   sts,
  output logic                    in_ready,
  output logic                    out_ld,
  output smd_pkg::ctrl_cmd_t      cmd
);

  smd_pkg::state_t state_r;
  smd_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= smd_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_ld    = 1'b0;
    unique case (state_r)
      smd_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = smd_pkg::S_READ;
        end
      end
      smd_pkg::S_READ: begin
        cmd.rd_ops = 1'b1;
        state_nxt  = smd_pkg::S_EXEC;
      end
      smd_pkg::S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.ex_iter) state_nxt = smd_pkg::S_ITER;
        else if (sts.ex_mem) state_nxt = smd_pkg::S_MEM;
        else state_nxt = smd_pkg::S_WB;
      end
      smd_pkg::S_ITER: begin
        if (sts.md_done) state_nxt = smd_pkg::S_WB;
      end
      smd_pkg::S_MEM: begin
        cmd.mem   = 1'b1;
        state_nxt = smd_pkg::S_WB;
      end
      smd_pkg::S_WB: begin
        cmd.wb    = 1'b1;
        state_nxt = sts.wr2 ? smd_pkg::S_WB2 : smd_pkg::S_TOP;
      end
      smd_pkg::S_WB2: begin
        cmd.wb2   = 1'b1;
        state_nxt = smd_pkg::S_TOP;
      end
      smd_pkg::S_TOP: begin
        cmd.rd_top = 1'b1;
        state_nxt  = smd_pkg::S_OUT;
      end
      smd_pkg::S_OUT: begin
        if (out_free) begin
          out_ld    = 1'b1;
          state_nxt = smd_pkg::S_IDLE;
        end
      end
      default: state_nxt = smd_pkg::S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ----- hw/rtl/stack_machine_data_unit.sv -----
// Stack machine data unit: runs one primitive per item on a 64-bit data
// stack (1024 cells, grows downward) beside a 4096-cell data memory.
// Input channel in_valid/in_ready/in_data carries op and literal; result
// channel out_valid/out_ready/out_data carries top of stack, depth, emit
// and branch flags and a status code. Every item gives exactly one result.
// Items are handled one at a time by a state machine over a single-port-
// write stack memory. Each item passes through read, exec, writeback,
// top-read and output states; fetch, cfetch and cstore add a cell memory
// read state, and mul and divmod wait on a shared one-bit-per-cycle unit
// (divmod adds a state for its second stack write). A new item is
// accepted in the cycle after the previous result is loaded.
// The result sits in an output register, so a stalled receiver does not
// block the next item from starting; only its result waits.
// Reset (rst_n low, synchronous) empties the stack; stack and data memory
// contents are undefined until written. No clearing pass is run.
// Failed steps report a nonzero status and leave all state unchanged.
`default_nettype none
module stack_machine_data_unit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire smd_pkg::in_item_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output smd_pkg::out_item_t       out_data
);

  smd_pkg::ctrl_cmd_t  cmd;
  smd_pkg::dp_sts_t    sts;
  smd_pkg::out_item_t  res;
  smd_pkg::out_item_t  out_data_r;
  logic                out_valid_r;
  logic                out_ld;
  logic                out_free;

  assign out_free = !out_valid_r || out_ready;

  smd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .sts      (sts),
    .in_ready (in_ready),
    .out_ld   (out_ld),
    .cmd      (cmd)
  );

  smd_dpath u_dpath (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_item (in_data),
    .sts     (sts),
    .res     (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // one item in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item accepted while busy");

  // failed steps never emit or branch
  a_fail_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status != smd_pkg::ST_OK)) |->
      (!out_data.emit_valid && !out_data.branch_taken))
    else $error("failed step flagged emit or branch");

  // depth never exceeds the stack size
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.depth <= 11'(smd_pkg::STACK_DEPTH)))
    else $error("depth out of range");

  // a result is loaded only into a free output slot
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_ld |-> out_free)
    else $error("pending result overwritten");

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import smd_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  // shadow of the machine state
  logic [63:0] stk [STACK_DEPTH];
  bit          stk_ok [STACK_DEPTH];
  logic [63:0] mem [MEM_CELLS];
  logic [7:0]  mem_ok [MEM_CELLS];
  int          sp;

  out_item_t pending_results[$];
  int send_idle = 0;
  int recv_idle = 0;
  int items_sent = 0;
  int results_seen = 0;
  int errors = 0;
  int op_hits [32];

  stack_machine_data_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #1 clk = ~clk;

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

  // Executes one primitive on the shadow state. Returns 0 when the item would
  // read a stack or memory entry that was never written; state changes only
  // when commit is set and the item is legal.
  function automatic bit machine_step(input in_item_t it, input bit commit,
                                      output out_item_t r);
    logic [63:0] a, b, v, topv, mv;
    logic [7:0]  mmask, bv;
    int nsi, w0i, w1i, mi, bi, d;
    logic [63:0] w0v, w1v;
    bit w0, w1, mw, safe, ev, bt;
    logic [7:0] ec;
    status_t st;
    safe = 1; nsi = sp; w0 = 0; w1 = 0; mw = 0; st = ST_OK;
    ev = 0; bt = 0; ec = '0; d = STACK_DEPTH - sp;
    w0i = 0; w1i = 0; w0v = '0; w1v = '0; mi = 0; mv = '0; mmask = '0;
    case (it.op)
      OP_LIT, OP_CELL, OP_DSPGET: begin
        if (d >= STACK_DEPTH) st = ST_OVER;
        else begin
          w0 = 1; w0i = sp - 1; nsi = sp - 1;
          w0v = (it.op == OP_LIT) ? it.literal :
                (it.op == OP_CELL) ? 64'd8 : 64'(sp);
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_XOR, OP_LT, OP_ULT, OP_EQ,
      OP_SHL, OP_SHR, OP_SAR: begin
        if (d < 2) st = ST_UNDER;
        else begin
          safe &= stk_ok[sp] & stk_ok[sp+1];
          a = stk[sp+1]; b = stk[sp];
          case (it.op)
            OP_ADD: v = a + b;
            OP_SUB: v = a - b;
            OP_MUL: v = a * b;
            OP_AND: v = a & b;
            OP_OR:  v = a | b;
            OP_XOR: v = a ^ b;
            OP_LT:  v = ($signed(a) < $signed(b)) ? 64'd1 : 64'd0;
            OP_ULT: v = (a < b) ? 64'd1 : 64'd0;
            OP_EQ:  v = (a == b) ? 64'd1 : 64'd0;
            OP_SHL: v = a << b[5:0];
            OP_SHR: v = a >> b[5:0];
            default: v = $signed(a) >>> b[5:0];
          endcase
          w0 = 1; w0i = sp + 1; w0v = v; nsi = sp + 1;
        end
      end
      OP_DIVMOD: begin
        if (d < 2) st = ST_UNDER;
        else begin
          safe &= stk_ok[sp] & stk_ok[sp+1];
          a = stk[sp+1]; b = stk[sp];
          if (b == 0) st = ST_DIV0;
          else begin
            w0 = 1; w0i = sp + 1; w0v = a % b;
            w1 = 1; w1i = sp; w1v = a / b;
          end
        end
      end
      OP_FETCH, OP_CFETCH: begin
        if (d < 1) st = ST_UNDER;
        else begin
          safe &= stk_ok[sp];
          a = stk[sp];
          if (a >= 64'(MEM_CELLS * 8) || (it.op == OP_FETCH && a[2:0] != 0)) st = ST_ADDR;
          else begin
            mi = int'(a >> 3); bi = int'(a[2:0]);
            w0 = 1; w0i = sp;
            if (it.op == OP_FETCH) begin
              safe &= (mem_ok[mi] == 8'hff);
              w0v = mem[mi];
            end else begin
              safe &= mem_ok[mi][bi];
              bv = mem[mi][bi*8 +: 8];
              w0v = {{56{bv[7]}}, bv};
            end
          end
        end
      end
      OP_STORE, OP_CSTORE: begin
        if (d < 2) st = ST_UNDER;
        else begin
          safe &= stk_ok[sp] & stk_ok[sp+1];
          a = stk[sp]; b = stk[sp+1];
          if (a >= 64'(MEM_CELLS * 8) || (it.op == OP_STORE && a[2:0] != 0)) st = ST_ADDR;
          else begin
            mi = int'(a >> 3); bi = int'(a[2:0]); mw = 1; nsi = sp + 2;
            if (it.op == OP_STORE) begin
              mv = b; mmask = 8'hff;
            end else begin
              mv = mem[mi]; mv[bi*8 +: 8] = b[7:0];
              mmask = mem_ok[mi] | (8'd1 << bi);
            end
          end
        end
      end
      OP_DSPSET: begin
        if (d < 1) st = ST_UNDER;
        else begin
          safe &= stk_ok[sp];
          v = stk[sp];
          if (v > 64'(STACK_DEPTH)) st = ST_ADDR;
          else nsi = int'(v);
        end
      end
      OP_EMIT, OP_BRANCH0: begin
        if (d < 1) st = ST_UNDER;
        else begin
          safe &= stk_ok[sp];
          v = stk[sp]; nsi = sp + 1;
          if (it.op == OP_EMIT) begin
            ev = 1; ec = v[7:0];
          end else bt = (v == 0);
        end
      end
      default: ;
    endcase
    // top of stack after the step
    if (nsi == STACK_DEPTH) topv = '0;
    else if (w0 && w0i == nsi) topv = w0v;
    else if (w1 && w1i == nsi) topv = w1v;
    else begin
      safe &= stk_ok[nsi];
      topv = stk[nsi];
    end
    r.top_value = topv;
    r.depth = 11'(STACK_DEPTH - nsi);
    r.emit_valid = ev;
    r.emit_char = ec;
    r.branch_taken = bt;
    r.status = st;
    if (commit && safe) begin
      if (w0) begin stk[w0i] = w0v; stk_ok[w0i] = 1; end
      if (w1) begin stk[w1i] = w1v; stk_ok[w1i] = 1; end
      if (mw) begin mem[mi] = mv; mem_ok[mi] = mmask; end
      sp = nsi;
    end
    return safe;
  endfunction

  // Sends one item; an item that would read unwritten storage becomes a
  // literal push of the same value.
  task automatic push_item(input logic [4:0] op, input logic [63:0] lit);
    in_item_t it;
    out_item_t r;
    it.op = op;
    it.literal = lit;
    if (!machine_step(it, 1'b0, r)) it.op = OP_LIT;
    void'(machine_step(it, 1'b1, r));
    pending_results.push_back(r);
    items_sent++;
    op_hits[it.op]++;
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Result checker and receiver stall
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, actual %p", $time, out_data);
        errors++;
      end else begin
        out_item_t e;
        e = pending_results.pop_front();
        if (out_data.top_value !== e.top_value) begin
          $display("%0t: top_value expected %h actual %h", $time, e.top_value,
                   out_data.top_value);
          errors++;
        end
        if (out_data.depth !== e.depth) begin
          $display("%0t: depth expected %0d actual %0d", $time, e.depth, out_data.depth);
          errors++;
        end
        if (out_data.emit_valid !== e.emit_valid) begin
          $display("%0t: emit_valid expected %b actual %b", $time, e.emit_valid,
                   out_data.emit_valid);
          errors++;
        end
        if (out_data.emit_char !== e.emit_char) begin
          $display("%0t: emit_char expected %h actual %h", $time, e.emit_char,
                   out_data.emit_char);
          errors++;
        end
        if (out_data.branch_taken !== e.branch_taken) begin
          $display("%0t: branch_taken expected %b actual %b", $time, e.branch_taken,
                   out_data.branch_taken);
          errors++;
        end
        if (out_data.status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, out_data.status);
          errors++;
        end
      end
    end
    out_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  function automatic logic [63:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 64'($urandom_range(0, 15));
      1: return {$urandom, $urandom};
      2: return 64'h8000_0000_0000_0000;
      3: return 64'h7fff_ffff_ffff_ffff;
      4: return '1;
      default: return 64'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [63:0] rand_addr(input bit byte_wide);
    case ($urandom_range(0, 9))
      0: return 64'(MEM_CELLS * 8 - 8);
      1: return 64'(MEM_CELLS * 8 - 1 - $urandom_range(0, 7));
      2: return 64'(MEM_CELLS * 8) + 64'($urandom_range(0, 100));
      3: return {$urandom, $urandom};
      default: return byte_wide ? 64'($urandom_range(0, 511)) : 64'($urandom_range(0, 63) * 8);
    endcase
  endfunction

  // Empty stack: every consumer underflows; unknown ops are no-ops; then a short push, add and emit run
  task automatic test_empty_stack();
    push_item(OP_ADD, '0);
    push_item(OP_DIVMOD, '0);
    push_item(OP_FETCH, '0);
    push_item(OP_STORE, '0);
    push_item(OP_DSPSET, '0);
    push_item(OP_EMIT, '0);
    push_item(OP_BRANCH0, '0);
    push_item(5'd23, '1);
    push_item(5'd31, '0);
    push_item(OP_DSPGET, '0);
    push_item(OP_CELL, '0);
    push_item(OP_ADD, '0);
    push_item(OP_EMIT, '0);
  endtask

  // Each binary op on extreme operands, shift counts 63 and 64; then divmod by zero and by 7, emit and branch0
  task automatic test_alu();
    op_t ops [12] = '{OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_XOR, OP_LT, OP_ULT,
                      OP_EQ, OP_SHL, OP_SHR, OP_SAR};
    foreach (ops[i]) begin
      push_item(OP_LIT, 64'h8000_0000_0000_0001);
      push_item(OP_LIT, (ops[i] >= OP_SHL) ? 64'(63 + (i % 2)) : 64'h7fff_ffff_ffff_ffff);
      push_item(ops[i], '0);
    end
    push_item(OP_LIT, '1);
    push_item(OP_LIT, '0);
    push_item(OP_DIVMOD, '0);
    push_item(OP_LIT, 64'd7);
    push_item(OP_DIVMOD, '0);
    push_item(OP_EMIT, '0);
    push_item(OP_BRANCH0, '0);
    push_item(OP_LIT, '0);
    push_item(OP_BRANCH0, '0);
  endtask

  // Cell and byte access, alignment and range limits
  task automatic test_memory();
    push_item(OP_LIT, 64'h8877_6655_4433_2211);
    push_item(OP_LIT, '0);
    push_item(OP_STORE, '0);
    push_item(OP_LIT, 64'd7);
    push_item(OP_CFETCH, '0);
    push_item(OP_LIT, 64'hff);
    push_item(OP_LIT, 64'(MEM_CELLS * 8 - 1));
    push_item(OP_CSTORE, '0);
    push_item(OP_LIT, 64'(MEM_CELLS * 8 - 1));
    push_item(OP_CFETCH, '0);
    push_item(OP_LIT, 64'(MEM_CELLS * 8));
    push_item(OP_CFETCH, '0);
    push_item(OP_LIT, 64'd3);
    push_item(OP_FETCH, '0);
    push_item(OP_STORE, '0);
    push_item(OP_LIT, '0);
    push_item(OP_FETCH, '0);
  endtask

  // Stack pointer read/write, bad index, overflow from a full stack
  task automatic test_stack_limits();
    push_item(OP_DSPGET, '0);
    push_item(OP_LIT, 64'(STACK_DEPTH + 1));
    push_item(OP_DSPSET, '0);
    push_item(OP_LIT, 64'(STACK_DEPTH));
    push_item(OP_DSPSET, '0);
    for (int i = 0; i < STACK_DEPTH - 1; i++) push_item(OP_LIT, rand_value());
    push_item(OP_LIT, 64'(STACK_DEPTH));
    push_item(OP_CELL, '0);
    push_item(OP_DSPGET, '0);
    push_item(OP_LIT, '0);
    push_item(OP_DSPSET, '0);
  endtask

  // Random short programs with random content
  task automatic test_random(input int count);
    int stop;
    stop = items_sent + count;
    while (items_sent < stop) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          push_item(OP_LIT, rand_value());
          push_item(OP_LIT, rand_value());
          push_item(5'($urandom_range(OP_ADD, OP_DIVMOD)), rand_value());
        end
        3: begin
          bit cb;
          cb = $urandom_range(0, 1);
          push_item(OP_LIT, rand_value());
          push_item(OP_LIT, rand_addr(cb));
          push_item(cb ? OP_CSTORE : OP_STORE, '0);
        end
        4: begin
          bit cb;
          cb = $urandom_range(0, 1);
          push_item(OP_LIT, rand_addr(cb));
          push_item(cb ? OP_CFETCH : OP_FETCH, '0);
        end
        5: begin
          if ($urandom_range(0, 1)) push_item(OP_DSPGET, '0);
          else begin
            push_item(OP_LIT, ($urandom_range(0, 5) == 0) ? rand_value() :
                      64'(sp + $urandom_range(0, 4)));
            push_item(OP_DSPSET, '0);
          end
        end
        6: begin
          if ($urandom_range(0, 1)) push_item(OP_LIT, rand_value());
          push_item($urandom_range(0, 1) ? OP_EMIT : OP_BRANCH0, '0);
        end
        7: push_item(5'($urandom_range(0, OP_BRANCH0)), rand_value());
        8: push_item(5'($urandom_range(0, 31)), rand_value());
        default: begin
          if (STACK_DEPTH - sp > 20) begin
            push_item(OP_LIT, 64'(STACK_DEPTH));
            push_item(OP_DSPSET, '0);
          end else push_item(OP_CELL, '0);
        end
      endcase
    end
  endtask

  initial begin
    int extra;
    sp = STACK_DEPTH;
    foreach (stk_ok[i]) stk_ok[i] = 0;
    foreach (mem_ok[i]) mem_ok[i] = '0;
    foreach (op_hits[i]) op_hits[i] = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // slow sender, mostly stalled receiver
    send_idle = 38; recv_idle = 82;
    test_empty_stack();
    test_alu();
    test_memory();
    test_random(30);
    // mostly idle sender, occasionally stalled receiver
    send_idle = 82; recv_idle = 38;
    test_stack_limits();
    // full speed on both sides
    send_idle = 0; recv_idle = 0;
    test_random(30);
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    extra = 0;
    for (int i = 23; i < 32; i++) extra += op_hits[i];
    $display("Ran %0d items (%0d unknown-op), checked %0d results, incl. full-stack overflow",
             items_sent, extra, results_seen);
    $display("and memory access at both ends of the address range.");
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
